/* hdl/iirl_pkg.sv */
package iirl_pkg;

  localparam int CNT_W  = 7;
  localparam int DATA_W = 32;

  localparam logic [CNT_W-1:0] LIMIT_RESET = 7'd64;

  typedef enum logic [2:0] {
    REQ_PUSH_BACK  = 3'd0,
    REQ_PUSH_FRONT = 3'd1,
    REQ_INSERT     = 3'd2,
    REQ_REMOVE_AT  = 3'd3,
    REQ_REM_FRONT  = 3'd4,
    REQ_REM_BACK   = 3'd5,
    REQ_READ       = 3'd6,
    REQ_WRITE      = 3'd7
  } req_type_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    OP_INS = 2'd0,
    OP_REM = 2'd1,
    OP_RD  = 2'd2,
    OP_WR  = 2'd3
  } op_t;

endpackage

/* hdl/iirl_if.sv */
interface iirl_req_if;
  logic                                valid;
  logic                                ready;
  logic [2:0]                          req_type;
  logic [iirl_pkg::CNT_W-1:0]          position;
  logic signed [iirl_pkg::DATA_W-1:0]  data_word;

  modport source (output valid, output req_type, output position, output data_word,
                  input ready);
  modport sink   (input valid, input req_type, input position, input data_word,
                  output ready);
endinterface

interface iirl_rsp_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          status;
  logic signed [iirl_pkg::DATA_W-1:0]  read_value;
  logic [iirl_pkg::CNT_W-1:0]          entry_count;
  logic signed [iirl_pkg::DATA_W-1:0]  running_total;

  modport source (output valid, output status, output read_value, output entry_count,
                  output running_total, input ready);
  modport sink   (input valid, input status, input read_value, input entry_count,
                  input running_total, output ready);
endinterface

/* hdl/iirl_ram.sv */
// Simple dual-port RAM: one write port, one read port with registered data.
module iirl_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                        clk,
  input  logic                        rd_en,
  input  logic [AW-1:0]               rd_addr,
  output logic [iirl_pkg::DATA_W-1:0] rd_data,
  input  logic                        wr_en,
  input  logic [AW-1:0]               wr_addr,
  input  logic [iirl_pkg::DATA_W-1:0] wr_data
);

  logic [iirl_pkg::DATA_W-1:0] mem [DEPTH];
  logic [iirl_pkg::DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* hdl/indexed_insert_remove_list.sv */
// Channel   Direction  Handshake            Payload
// in_req    sink       valid / ready        req_type, position, data_word
// out_rsp   source     valid / ready        status, read_value, entry_count, running_total
// cfg       write only cfg_we               cfg_wdata (list limit)
//
// One request is worked on at a time. A refused request goes from S_IDLE straight to S_FIN,
// a read or write passes S_LOOK and S_GOT, an insert passes S_SHIFT and a removal all three;
// the length of a shift is set by the single read and single write port of the entry RAM,
// through which the shift moves one entry per cycle.
// Reset (rst_n low, synchronous) empties the list, clears the sum and sets the limit to 64.
// A new request is taken whenever the sequencer is idle, even while a response waits in
// the output register; a stalled response only holds the sequencer at its final step.

module indexed_insert_remove_list #(
  parameter int DEPTH = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [iirl_pkg::CNT_W-1:0]  cfg_wdata,
  iirl_req_if.sink                    in_req,
  iirl_rsp_if.source                  out_rsp
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = iirl_pkg::CNT_W;
  localparam int DW = iirl_pkg::DATA_W;
  // Largest limit that the storage can honour; the 7-bit limit register never exceeds 127.
  localparam logic [CW-1:0] DEPTH_CAP = (DEPTH < 127) ? CW'(DEPTH) : CW'(127);

  // One-hot sequencer states.
  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_LOOK  = 5'b00010,
    S_GOT   = 5'b00100,
    S_SHIFT = 5'b01000,
    S_FIN   = 5'b10000
  } state_t;

  state_t            state_r, state_nxt;
  iirl_pkg::op_t     op_r, op_nxt;
  iirl_pkg::status_t status_r, status_nxt;
  logic [CW-1:0]     pos_r, pos_nxt;
  logic [DW-1:0]     val_r, val_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [DW-1:0]     sum_r, sum_nxt;
  logic [CW-1:0]     limit_r, limit_nxt;
  logic [AW-1:0]     cursor_r, cursor_nxt;
  logic [CW-1:0]     rem_r, rem_nxt;
  logic              wpend_r, wpend_nxt;
  logic [AW-1:0]     last_addr_r, last_addr_nxt;
  logic [DW-1:0]     rdval_r, rdval_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [1:0]        out_status_r, out_status_nxt;
  logic [DW-1:0]     out_read_r, out_read_nxt;
  logic [CW-1:0]     out_count_r, out_count_nxt;
  logic [DW-1:0]     out_sum_r, out_sum_nxt;

  // Request decode, evaluated against the current count when a request arrives.
  iirl_pkg::req_type_t req_type;
  logic [CW-1:0]       pos_eff;
  logic [CW-1:0]       eff_limit;
  logic                is_insert;
  iirl_pkg::op_t       dec_op;
  iirl_pkg::status_t   dec_status;

  logic [CW-1:0]       cnt_fin;
  logic [DW-1:0]       sum_fin;

  logic                ram_rd_en;
  logic [AW-1:0]       ram_rd_addr;
  logic [DW-1:0]       ram_rd_data;
  logic                ram_wr_en;
  logic [AW-1:0]       ram_wr_addr;
  logic [DW-1:0]       ram_wr_data;

  iirl_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data)
  );

  assign req_type  = iirl_pkg::req_type_t'(in_req.req_type);
  assign eff_limit = (limit_r < DEPTH_CAP) ? limit_r : DEPTH_CAP;

  always_comb begin
    pos_eff = in_req.position;
    dec_op  = iirl_pkg::OP_RD;
    case (req_type)
      iirl_pkg::REQ_PUSH_BACK: begin
        pos_eff = count_r;
        dec_op  = iirl_pkg::OP_INS;
      end
      iirl_pkg::REQ_PUSH_FRONT: begin
        pos_eff = '0;
        dec_op  = iirl_pkg::OP_INS;
      end
      iirl_pkg::REQ_INSERT: begin
        dec_op  = iirl_pkg::OP_INS;
      end
      iirl_pkg::REQ_REMOVE_AT: begin
        dec_op  = iirl_pkg::OP_REM;
      end
      iirl_pkg::REQ_REM_FRONT: begin
        pos_eff = '0;
        dec_op  = iirl_pkg::OP_REM;
      end
      iirl_pkg::REQ_REM_BACK: begin
        // On an empty list this wraps to 127 and so fails the range check below.
        pos_eff = count_r - CW'(1);
        dec_op  = iirl_pkg::OP_REM;
      end
      iirl_pkg::REQ_READ: begin
        dec_op  = iirl_pkg::OP_RD;
      end
      default: begin
        dec_op  = iirl_pkg::OP_WR;
      end
    endcase
  end

  assign is_insert = (dec_op == iirl_pkg::OP_INS);

  always_comb begin
    if (is_insert) begin
      // The index check comes before the full check.
      if (pos_eff > count_r) begin
        dec_status = iirl_pkg::ST_RANGE;
      end else if (count_r >= eff_limit) begin
        dec_status = iirl_pkg::ST_FULL;
      end else begin
        dec_status = iirl_pkg::ST_DONE;
      end
    end else if (pos_eff >= count_r) begin
      dec_status = iirl_pkg::ST_RANGE;
    end else begin
      dec_status = iirl_pkg::ST_DONE;
    end
  end

  assign in_req.ready = (state_r == S_IDLE);

  // Sequencer. Shifts stream through the RAM: a read is issued each cycle and its data is
  // written one place further along in the next. The read and write addresses in flight
  // always differ, and the final writes land before any later read of the same entry, so
  // no forwarding path is needed.
  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    status_nxt     = status_r;
    pos_nxt        = pos_r;
    val_nxt        = val_r;
    count_nxt      = count_r;
    sum_nxt        = sum_r;
    limit_nxt      = cfg_we ? cfg_wdata : limit_r;
    cursor_nxt     = cursor_r;
    rem_nxt        = rem_r;
    wpend_nxt      = wpend_r;
    last_addr_nxt  = last_addr_r;
    rdval_nxt      = rdval_r;
    cnt_fin        = count_r;
    sum_fin        = sum_r;

    out_valid_nxt  = out_valid_r && !out_rsp.ready;
    out_status_nxt = out_status_r;
    out_read_nxt   = out_read_r;
    out_count_nxt  = out_count_r;
    out_sum_nxt    = out_sum_r;

    ram_rd_en      = 1'b0;
    ram_rd_addr    = cursor_r;
    ram_wr_en      = 1'b0;
    ram_wr_addr    = AW'(pos_r);
    ram_wr_data    = ram_rd_data;

    case (state_r)
      S_IDLE: begin
        if (in_req.valid) begin
          op_nxt     = dec_op;
          status_nxt = dec_status;
          pos_nxt    = pos_eff;
          val_nxt    = in_req.data_word;
          rdval_nxt  = '0;
          wpend_nxt  = 1'b0;
          if (dec_status != iirl_pkg::ST_DONE) begin
            state_nxt = S_FIN;
          end else if (is_insert) begin
            // Move entries [pos, count) up one place, starting at the top.
            cursor_nxt = AW'(count_r - CW'(1));
            rem_nxt    = count_r - pos_eff;
            state_nxt  = S_SHIFT;
          end else begin
            state_nxt = S_LOOK;
          end
        end
      end

      S_LOOK: begin
        ram_rd_en   = 1'b1;
        ram_rd_addr = AW'(pos_r);
        state_nxt   = S_GOT;
      end

      S_GOT: begin
        case (op_r)
          iirl_pkg::OP_RD: begin
            rdval_nxt = ram_rd_data;
            state_nxt = S_FIN;
          end
          iirl_pkg::OP_WR: begin
            ram_wr_en   = 1'b1;
            ram_wr_data = val_r;
            sum_nxt     = sum_r + val_r - ram_rd_data;
            state_nxt   = S_FIN;
          end
          default: begin
            // Removal: take the old entry out of the sum, then close the gap from below.
            sum_nxt    = sum_r - ram_rd_data;
            cursor_nxt = AW'(pos_r + CW'(1));
            rem_nxt    = count_r - pos_r - CW'(1);
            state_nxt  = S_SHIFT;
          end
        endcase
      end

      S_SHIFT: begin
        if (wpend_r) begin
          ram_wr_en   = 1'b1;
          ram_wr_addr = (op_r == iirl_pkg::OP_INS) ? last_addr_r + AW'(1)
                                                   : last_addr_r - AW'(1);
        end
        if (rem_r != '0) begin
          ram_rd_en     = 1'b1;
          last_addr_nxt = cursor_r;
          cursor_nxt    = (op_r == iirl_pkg::OP_INS) ? cursor_r - AW'(1)
                                                     : cursor_r + AW'(1);
          rem_nxt       = rem_r - CW'(1);
          wpend_nxt     = 1'b1;
        end else begin
          wpend_nxt = 1'b0;
          if (!wpend_r) begin
            state_nxt = S_FIN;
          end
        end
      end

      S_FIN: begin
        if (!out_valid_r || out_rsp.ready) begin
          if (status_r == iirl_pkg::ST_DONE) begin
            case (op_r)
              iirl_pkg::OP_INS: begin
                ram_wr_en   = 1'b1;
                ram_wr_data = val_r;
                cnt_fin     = count_r + CW'(1);
                sum_fin     = sum_r + val_r;
              end
              iirl_pkg::OP_REM: begin
                cnt_fin     = count_r - CW'(1);
              end
              default: begin
              end
            endcase
          end
          count_nxt      = cnt_fin;
          sum_nxt        = sum_fin;
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_read_nxt   = rdval_r;
          out_count_nxt  = cnt_fin;
          out_sum_nxt    = sum_fin;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      sum_r       <= '0;
      limit_r     <= iirl_pkg::LIMIT_RESET;
      wpend_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      sum_r       <= sum_nxt;
      limit_r     <= limit_nxt;
      wpend_r     <= wpend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    status_r     <= status_nxt;
    pos_r        <= pos_nxt;
    val_r        <= val_nxt;
    cursor_r     <= cursor_nxt;
    rem_r        <= rem_nxt;
    last_addr_r  <= last_addr_nxt;
    rdval_r      <= rdval_nxt;
    out_status_r <= out_status_nxt;
    out_read_r   <= out_read_nxt;
    out_count_r  <= out_count_nxt;
    out_sum_r    <= out_sum_nxt;
  end

  assign out_rsp.valid         = out_valid_r;
  assign out_rsp.status        = out_status_r;
  assign out_rsp.read_value    = out_read_r;
  assign out_rsp.entry_count   = out_count_r;
  assign out_rsp.running_total = out_sum_r;

endmodule
